@@ rtl/gha_pkg.sv @@
package gha_pkg;

    // Width of the generation field on both channels.
    localparam int GEN_FIELD_W = 16;

    typedef enum logic [1:0] {
        CMD_CREATE  = 2'd0,
        CMD_DESTROY = 2'd1,
        CMD_ALIVE   = 2'd2,
        CMD_COMMIT  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK          = 2'd0,
        STAT_TABLE_FULL  = 2'd1,
        STAT_INVALID     = 2'd2,
        STAT_QUEUE_FULL  = 2'd3
    } status_t;

    // Port strobes of a one-read, one-write memory.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

endpackage

@@ rtl/gha_slot_table.sv @@
module gha_slot_table #(
    parameter int DEPTH = 1024,
    parameter int DW    = 27
) (
    input  logic                       aclk,
    input  gha_pkg::mem_ctl_t          ctl,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  logic [DW-1:0]              wr_data,
    output logic [DW-1:0]              rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] q_reg;
    logic [DW-1:0] byp_data_reg;
    logic          byp_reg;

    // The array reads old data on a same-address collision, so the write that
    // lands in the same cycle is captured and returned in its place.
    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en) begin
            q_reg        <= mem[rd_addr];
            byp_reg      <= ctl.wr_en && (wr_addr == rd_addr);
            byp_data_reg <= wr_data;
        end
    end

    assign rd_data = byp_reg ? byp_data_reg : q_reg;

endmodule

@@ rtl/gha_pend_queue.sv @@
module gha_pend_queue #(
    parameter int DEPTH = 64,
    parameter int DW    = 26
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  gha_pkg::mem_ctl_t                            ctl,
    input  logic                                         clear,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    input  logic [DW-1:0]                                wr_data,
    output logic [DW-1:0]                                rd_data,
    output logic [$clog2(DEPTH+1)-1:0]                   count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] q_reg;
    logic [CW-1:0] count_reg;

    // Pushes append at the fill count; the caller never pushes when full.
    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[count_reg[AW-1:0]] <= wr_data;
        end
        if (ctl.rd_en) begin
            q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (clear) begin
            count_reg <= '0;
        end else if (ctl.wr_en) begin
            count_reg <= count_reg + CW'(1);
        end
    end

    assign rd_data = q_reg;
    assign count   = count_reg;

endmodule

@@ rtl/generational_handle_allocator.sv @@
// Flow: a create that takes a never-used slot, a destroy and an alive query on a
// null or never-used handle give their result straight from idle; a create
// from the free list and a live alive query first make one slot table read.
// A commit walks one queue entry and one slot per cycle and then empties the queue.
// The next item is taken only once the result has entered the output register.
// Synchronous active-low reset empties the free list, the queue and the live count.
module generational_handle_allocator #(
    parameter int TABLE_DEPTH     = 1024,
    parameter int GENERATION_BITS = 16,
    parameter int PENDING_DEPTH   = 64
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [1:0]                            s_command,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0]      s_handle_index,
    input  logic [gha_pkg::GEN_FIELD_W-1:0]       s_handle_generation,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [1:0]                            m_status,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]      m_new_index,
    output logic [gha_pkg::GEN_FIELD_W-1:0]       m_new_generation,
    output logic                                  m_is_alive,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]      m_live_count,
    output logic [$clog2(PENDING_DEPTH+1)-1:0]    m_freed_count
);

    // Index field width holds the null handle; slot addresses do not need to.
    localparam int IDX_W   = $clog2(TABLE_DEPTH + 1);
    localparam int SA_W    = $clog2(TABLE_DEPTH);
    localparam int GB      = GENERATION_BITS;
    localparam int GW      = gha_pkg::GEN_FIELD_W;
    localparam int PA_W    = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int PC_W    = $clog2(PENDING_DEPTH + 1);
    localparam int CMP_W   = (GB > GW) ? GB : GW;
    // A slot word is {link, generation}; a live slot links to itself.
    localparam int SLOT_W  = IDX_W + GB;
    localparam int PEND_W  = SA_W + GW;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_LOOK   = 4'b0010,
        S_COMMIT = 4'b0100,
        S_HOLD   = 4'b1000
    } state_t;

    typedef struct packed {
        gha_pkg::status_t   status;
        logic [IDX_W-1:0]   new_index;
        logic [GW-1:0]      new_gen;
        logic               alive;
        logic [IDX_W-1:0]   live;
        logic [PC_W-1:0]    freed;
    } res_t;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    slots_used_reg, slots_used_next;
    logic [IDX_W-1:0]    free_head_reg, free_head_next;
    logic [IDX_W-1:0]    live_reg, live_next;
    gha_pkg::cmd_t       cmd_reg, cmd_next;
    logic [SA_W-1:0]     idx_reg, idx_next;
    logic [GW-1:0]       gen_reg, gen_next;
    logic [PC_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic                s1_v_reg, s1_v_next;
    logic                s2_v_reg, s2_v_next;
    logic [SA_W-1:0]     s2_idx_reg, s2_idx_next;
    logic [GW-1:0]       s2_gen_reg, s2_gen_next;
    logic [PC_W-1:0]     freed_reg, freed_next;
    res_t                res_next, m_res_reg, hold_reg;
    logic                m_valid_reg;

    gha_pkg::cmd_t       in_cmd;
    logic                done;
    logic                out_free;

    gha_pkg::mem_ctl_t   slot_ctl;
    logic [SA_W-1:0]     slot_rd_addr, slot_wr_addr;
    logic [SLOT_W-1:0]   slot_wr_data, slot_rd_data;
    logic [IDX_W-1:0]    sd_link;
    logic [GB-1:0]       sd_gen;
    logic [GB-1:0]       sd_gen_inc;

    gha_pkg::mem_ctl_t   pend_ctl;
    logic                pend_clear;
    logic [PEND_W-1:0]   pend_wr_data, pend_rd_data;
    logic [PC_W-1:0]     pend_count;
    logic [SA_W-1:0]     pd_idx;
    logic [GW-1:0]       pd_gen;

    gha_slot_table #(
        .DEPTH (TABLE_DEPTH),
        .DW    (SLOT_W)
    ) u_slots (
        .aclk    (aclk),
        .ctl     (slot_ctl),
        .rd_addr (slot_rd_addr),
        .wr_addr (slot_wr_addr),
        .wr_data (slot_wr_data),
        .rd_data (slot_rd_data)
    );

    gha_pend_queue #(
        .DEPTH (PENDING_DEPTH),
        .DW    (PEND_W)
    ) u_pend (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (pend_ctl),
        .clear   (pend_clear),
        .rd_addr (rd_ptr_reg[PA_W-1:0]),
        .wr_data (pend_wr_data),
        .rd_data (pend_rd_data),
        .count   (pend_count)
    );

    assign in_cmd   = gha_pkg::cmd_t'(s_command);
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);

    assign sd_link    = slot_rd_data[SLOT_W-1:GB];
    assign sd_gen     = slot_rd_data[GB-1:0];
    // The generation wraps at its own width.
    assign sd_gen_inc = sd_gen + GB'(1);
    assign pd_idx     = pend_rd_data[PEND_W-1:GW];
    assign pd_gen     = pend_rd_data[GW-1:0];

    always_comb begin
        state_next      = state_reg;
        slots_used_next = slots_used_reg;
        free_head_next  = free_head_reg;
        live_next       = live_reg;
        cmd_next        = cmd_reg;
        idx_next        = idx_reg;
        gen_next        = gen_reg;
        rd_ptr_next     = rd_ptr_reg;
        s1_v_next       = 1'b0;
        s2_v_next       = 1'b0;
        s2_idx_next     = s2_idx_reg;
        s2_gen_next     = s2_gen_reg;
        freed_next      = freed_reg;
        done            = 1'b0;

        res_next.status    = gha_pkg::STAT_OK;
        res_next.new_index = IDX_W'(TABLE_DEPTH);
        res_next.new_gen   = '0;
        res_next.alive     = 1'b0;
        res_next.live      = live_reg;
        res_next.freed     = '0;

        slot_ctl      = '0;
        slot_rd_addr  = '0;
        slot_wr_addr  = '0;
        slot_wr_data  = '0;
        pend_ctl      = '0;
        pend_clear    = 1'b0;
        pend_wr_data  = {s_handle_index[SA_W-1:0], s_handle_generation};

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd_next = in_cmd;
                    idx_next = s_handle_index[SA_W-1:0];
                    gen_next = s_handle_generation;
                    unique case (in_cmd)
                        gha_pkg::CMD_CREATE: begin
                            if (free_head_reg < IDX_W'(TABLE_DEPTH)) begin
                                // Reuse the free-list head: its link is needed first.
                                slot_ctl.rd_en = 1'b1;
                                slot_rd_addr   = free_head_reg[SA_W-1:0];
                                state_next     = S_LOOK;
                            end else if (slots_used_reg < IDX_W'(TABLE_DEPTH)) begin
                                slot_ctl.wr_en     = 1'b1;
                                slot_wr_addr       = slots_used_reg[SA_W-1:0];
                                slot_wr_data       = {slots_used_reg, GB'(0)};
                                slots_used_next    = slots_used_reg + IDX_W'(1);
                                live_next          = live_reg + IDX_W'(1);
                                res_next.new_index = slots_used_reg;
                                done               = 1'b1;
                            end else begin
                                res_next.status = gha_pkg::STAT_TABLE_FULL;
                                done            = 1'b1;
                            end
                        end
                        gha_pkg::CMD_DESTROY: begin
                            done = 1'b1;
                            if (s_handle_index >= IDX_W'(TABLE_DEPTH)) begin
                                res_next.status = gha_pkg::STAT_INVALID;
                            end else if (pend_count >= PC_W'(PENDING_DEPTH)) begin
                                res_next.status = gha_pkg::STAT_QUEUE_FULL;
                            end else begin
                                pend_ctl.wr_en = 1'b1;
                            end
                        end
                        gha_pkg::CMD_ALIVE: begin
                            if ((s_handle_index < IDX_W'(TABLE_DEPTH)) &&
                                (s_handle_index < slots_used_reg)) begin
                                slot_ctl.rd_en = 1'b1;
                                slot_rd_addr   = s_handle_index[SA_W-1:0];
                                state_next     = S_LOOK;
                            end else begin
                                done = 1'b1;
                            end
                        end
                        gha_pkg::CMD_COMMIT: begin
                            rd_ptr_next = '0;
                            freed_next  = '0;
                            state_next  = S_COMMIT;
                        end
                        default: begin
                            done = 1'b1;
                        end
                    endcase
                end
            end

            S_LOOK: begin
                done = 1'b1;
                if (cmd_reg == gha_pkg::CMD_CREATE) begin
                    // Pop the head, relink the slot to itself and bump its generation.
                    free_head_next     = sd_link;
                    slot_ctl.wr_en     = 1'b1;
                    slot_wr_addr       = free_head_reg[SA_W-1:0];
                    slot_wr_data       = {free_head_reg, sd_gen_inc};
                    live_next          = live_reg + IDX_W'(1);
                    res_next.new_index = free_head_reg;
                    res_next.new_gen   = GW'(sd_gen_inc);
                end else begin
                    res_next.alive = (sd_link == IDX_W'(idx_reg)) &&
                                     (CMP_W'(sd_gen) == CMP_W'(gen_reg));
                end
            end

            S_COMMIT: begin
                // Stage 0: read the next queue entry.
                if (rd_ptr_reg < pend_count) begin
                    pend_ctl.rd_en = 1'b1;
                    rd_ptr_next    = rd_ptr_reg + PC_W'(1);
                    s1_v_next      = 1'b1;
                end
                // Stage 1: read the entry's slot; entries beyond the used slots cannot be alive.
                if (s1_v_reg) begin
                    slot_ctl.rd_en = 1'b1;
                    slot_rd_addr   = pd_idx;
                    s2_v_next      = (IDX_W'(pd_idx) < slots_used_reg);
                    s2_idx_next    = pd_idx;
                    s2_gen_next    = pd_gen;
                end
                // Stage 2: free a still-live slot by pushing it on the free list.
                if (s2_v_reg && (sd_link == IDX_W'(s2_idx_reg)) &&
                    (CMP_W'(sd_gen) == CMP_W'(s2_gen_reg))) begin
                    slot_ctl.wr_en = 1'b1;
                    slot_wr_addr   = s2_idx_reg;
                    slot_wr_data   = {free_head_reg, sd_gen};
                    free_head_next = IDX_W'(s2_idx_reg);
                    if (live_reg != '0) begin
                        live_next = live_reg - IDX_W'(1);
                    end
                    freed_next = freed_reg + PC_W'(1);
                end
                if ((rd_ptr_reg == pend_count) && !s1_v_reg && !s2_v_reg) begin
                    pend_clear     = 1'b1;
                    res_next.freed = freed_reg;
                    done           = 1'b1;
                end
            end

            S_HOLD: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        res_next.live = live_next;

        if (done) begin
            state_next = out_free ? S_IDLE : S_HOLD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            slots_used_reg <= '0;
            free_head_reg  <= IDX_W'(TABLE_DEPTH);
            live_reg       <= '0;
            rd_ptr_reg     <= '0;
            s1_v_reg       <= 1'b0;
            s2_v_reg       <= 1'b0;
            freed_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            slots_used_reg <= slots_used_next;
            free_head_reg  <= free_head_next;
            live_reg       <= live_next;
            rd_ptr_reg     <= rd_ptr_next;
            s1_v_reg       <= s1_v_next;
            s2_v_reg       <= s2_v_next;
            freed_reg      <= freed_next;
            if (done && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (state_reg == S_HOLD) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        idx_reg    <= idx_next;
        gen_reg    <= gen_next;
        s2_idx_reg <= s2_idx_next;
        s2_gen_reg <= s2_gen_next;
        if (done && out_free) begin
            m_res_reg <= res_next;
        end else if ((state_reg == S_HOLD) && m_ready) begin
            m_res_reg <= hold_reg;
        end
        if (done && !out_free) begin
            hold_reg <= res_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_res_reg.status;
    assign m_new_index      = m_res_reg.new_index;
    assign m_new_generation = m_res_reg.new_gen;
    assign m_is_alive       = m_res_reg.alive;
    assign m_live_count     = m_res_reg.live;
    assign m_freed_count    = m_res_reg.freed;

    // Every live handle sits in a slot that has been handed out at least once.
    a_live_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        live_reg <= slots_used_reg)
        else $error("live count exceeds used slots");

    // The free list only ever holds slots that were handed out.
    a_free_head_used: assert property (@(posedge aclk) disable iff (!aresetn)
        (free_head_reg == IDX_W'(TABLE_DEPTH)) || (free_head_reg < slots_used_reg))
        else $error("free-list head outside the used slots");

    // Outside the fresh-slot create, slot writes touch only used slots.
    a_slot_write_used: assert property (@(posedge aclk) disable iff (!aresetn)
        (slot_ctl.wr_en && (state_reg != S_IDLE)) |->
            (IDX_W'(slot_wr_addr) < slots_used_reg))
        else $error("slot write beyond the used slots");

    a_pend_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_count <= PC_W'(PENDING_DEPTH))
        else $error("destroy queue overfilled");

    // A held result waits only while the output register is occupied.
    a_hold_needs_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_HOLD) |-> m_valid_reg)
        else $error("result held while output register is empty");

endmodule

@@ bench/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // The block is built at its default sizes; the widths below follow from them.
    localparam int TABLE_DEPTH   = 1024;
    localparam int PENDING_DEPTH = 64;
    localparam int GEN_W         = gha_pkg::GEN_FIELD_W;
    localparam int IDX_W         = $clog2(TABLE_DEPTH + 1);
    localparam int CNT_W         = $clog2(PENDING_DEPTH + 1);

    // Stimulus size. The quiet tail has no idling on either side.
    localparam int ITEMS_TOTAL   = 1600;
    localparam int QUIET_TAIL    = 150;
    localparam int FILL_AT       = 250;
    // Wait after the last result; it covers a commit of a full queue.
    localparam int DRAIN_CYCLES  = 80;
    localparam int LIMIT_CYCLES  = 2000000;

    // One item on the input channel.
    typedef struct packed {
        gha_pkg::cmd_t    cmd;
        logic [IDX_W-1:0] index;
        logic [GEN_W-1:0] gen;
    } alloc_item_t;

    // One item on the result channel.
    typedef struct packed {
        gha_pkg::status_t status;
        logic [IDX_W-1:0] new_index;
        logic [GEN_W-1:0] new_gen;
        logic             alive;
        logic [IDX_W-1:0] live;
        logic [CNT_W-1:0] freed;
    } alloc_result_t;

    logic             aclk    = 1'b0;
    logic             aresetn = 1'b0;

    logic             s_valid             = 1'b0;
    logic             s_ready;
    logic [1:0]       s_command           = '0;
    logic [IDX_W-1:0] s_handle_index      = '0;
    logic [GEN_W-1:0] s_handle_generation = '0;

    logic             m_valid;
    logic             m_ready             = 1'b0;
    logic [1:0]       m_status;
    logic [IDX_W-1:0] m_new_index;
    logic [GEN_W-1:0] m_new_generation;
    logic             m_is_alive;
    logic [IDX_W-1:0] m_live_count;
    logic [CNT_W-1:0] m_freed_count;

    generational_handle_allocator #(
        .TABLE_DEPTH     (TABLE_DEPTH),
        .GENERATION_BITS (GEN_W),
        .PENDING_DEPTH   (PENDING_DEPTH)
    ) u_top (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_command           (s_command),
        .s_handle_index      (s_handle_index),
        .s_handle_generation (s_handle_generation),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_status            (m_status),
        .m_new_index         (m_new_index),
        .m_new_generation    (m_new_generation),
        .m_is_alive          (m_is_alive),
        .m_live_count        (m_live_count),
        .m_freed_count       (m_freed_count)
    );

    always #1 aclk = ~aclk;

    // Shadow copy of the allocator state. A free slot's link holds the next free
    // slot and TABLE_DEPTH ends the list; a live slot links to itself.
    int unsigned      slot_link  [TABLE_DEPTH];
    logic [GEN_W-1:0] slot_gen   [TABLE_DEPTH];
    int unsigned      used_slots = 0;
    int unsigned      free_top   = TABLE_DEPTH;
    int unsigned      live_now   = 0;
    int unsigned      doomed_idx [PENDING_DEPTH];
    logic [GEN_W-1:0] doomed_gen [PENDING_DEPTH];
    int unsigned      doomed_n   = 0;

    // Items waiting to be driven, and results that the block still owes us.
    alloc_item_t      stim_q[$];
    alloc_result_t    owed_q[$];
    alloc_result_t    want;

    int unsigned      pushed_n   = 0;
    int unsigned      accepted_n = 0;
    int unsigned      fails      = 0;
    int unsigned      cycles     = 0;
    bit               item_took  = 1'b0;

    // Idling controls, changed by the stimulus process from one stretch to the next.
    int unsigned      gap_pct    = 0;
    int unsigned      stall_pct  = 0;
    int unsigned      gap_left   = 0;
    int unsigned      stall_left = 0;

    // What the run has exercised, for the closing summary.
    int unsigned      n_cmd [4];
    int unsigned      n_full     = 0;
    int unsigned      n_qfull    = 0;
    int unsigned      n_invalid  = 0;
    int unsigned      n_freed    = 0;
    int unsigned      n_hits     = 0;

    // A handle is alive only inside the used part of the table, when its slot links
    // to itself and the generations agree. Nothing beyond slots_used is ever read.
    function automatic logic handle_live(int unsigned idx, logic [GEN_W-1:0] g);
        if (idx >= TABLE_DEPTH || idx >= used_slots)
            return 1'b0;
        return (slot_link[idx] == idx) && (slot_gen[idx] == g);
    endfunction

    // Applies one accepted item to the shadow state and returns the result it owes.
    function automatic alloc_result_t alloc_predict(alloc_item_t it);
        alloc_result_t r;
        int unsigned   s;
        int unsigned   e;
        r           = '0;
        r.status    = gha_pkg::STAT_OK;
        r.new_index = IDX_W'(TABLE_DEPTH);
        n_cmd[it.cmd]++;
        unique case (it.cmd)
            gha_pkg::CMD_CREATE: begin
                if (free_top < TABLE_DEPTH) begin
                    // Reuse the head of the free list; its generation moves on and wraps.
                    s            = free_top;
                    free_top     = slot_link[s];
                    slot_link[s] = s;
                    slot_gen[s]  = slot_gen[s] + 1'b1;
                    r.new_index  = IDX_W'(s);
                    r.new_gen    = slot_gen[s];
                    live_now++;
                end else if (used_slots < TABLE_DEPTH) begin
                    s            = used_slots;
                    slot_link[s] = s;
                    slot_gen[s]  = '0;
                    used_slots++;
                    r.new_index  = IDX_W'(s);
                    live_now++;
                end else begin
                    r.status = gha_pkg::STAT_TABLE_FULL;
                    n_full++;
                end
            end
            gha_pkg::CMD_DESTROY: begin
                if (it.index >= TABLE_DEPTH) begin
                    r.status = gha_pkg::STAT_INVALID;
                    n_invalid++;
                end else if (doomed_n >= PENDING_DEPTH) begin
                    r.status = gha_pkg::STAT_QUEUE_FULL;
                    n_qfull++;
                end else begin
                    doomed_idx[doomed_n] = it.index;
                    doomed_gen[doomed_n] = it.gen;
                    doomed_n++;
                end
            end
            gha_pkg::CMD_ALIVE: begin
                r.alive = handle_live(it.index, it.gen);
                if (r.alive)
                    n_hits++;
            end
            gha_pkg::CMD_COMMIT: begin
                // Stale and repeated handles fall through the liveness test.
                for (int k = 0; k < doomed_n; k++) begin
                    e = doomed_idx[k];
                    if (handle_live(e, doomed_gen[k])) begin
                        slot_link[e] = free_top;
                        free_top     = e;
                        if (live_now > 0)
                            live_now--;
                        r.freed = r.freed + 1'b1;
                    end
                end
                n_freed  += r.freed;
                doomed_n  = 0;
            end
        endcase
        r.live = IDX_W'(live_now);
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] expd, logic [31:0] got);
        if (expd !== got) begin
            $error("%s mismatch: expected %0d, got %0d", name, expd, got);
            fails++;
        end
    endtask

    function automatic void queue_item(gha_pkg::cmd_t c, int unsigned idx, int unsigned g);
        alloc_item_t it;
        it.cmd   = c;
        it.index = idx[IDX_W-1:0];
        it.gen   = g[GEN_W-1:0];
        stim_q   = {stim_q, it};
        pushed_n++;
    endfunction

    // Picks a handle among the used slots as the shadow state stands now (any slot if none).
    // Most carry the slot's current generation; the rest are deliberately stale.
    function automatic void queue_known(gha_pkg::cmd_t c);
        int unsigned idx;
        int unsigned pick;
        if (used_slots == 0) begin
            queue_item(c, $urandom_range(TABLE_DEPTH - 1), $urandom);
        end else begin
            idx  = $urandom_range(used_slots - 1);
            pick = $urandom_range(9);
            if (pick < 7)
                queue_item(c, idx, slot_gen[idx]);
            else if (pick < 9)
                queue_item(c, idx, slot_gen[idx] - 1'b1);
            else
                queue_item(c, idx, $urandom);
        end
    endfunction

    // Driver: presents the next item at the falling edge and holds it, unchanged,
    // until the block has taken it. Gaps are only ever opened before an item is
    // raised, so valid never waits on ready.
    always @(negedge aclk) begin
        if (s_valid && !item_took) begin
            // Still waiting for the block to take the current item.
        end else if (gap_left > 0) begin
            s_valid <= 1'b0;
            gap_left--;
        end else if (stim_q.size() != 0 && $urandom_range(99) < gap_pct) begin
            s_valid  <= 1'b0;
            gap_left  = $urandom_range(12);
        end else if (stim_q.size() != 0) begin
            s_valid             <= 1'b1;
            s_command           <= stim_q[0].cmd;
            s_handle_index      <= stim_q[0].index;
            s_handle_generation <= stim_q[0].gen;
            void'(stim_q.pop_front());
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Receiver back-pressure: stall_pct sets how often a burst of low ready begins.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else if ($urandom_range(99) < stall_pct) begin
            m_ready    <= 1'b0;
            stall_left  = $urandom_range(12);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Monitor: at each rising edge an accepted input item is turned into the result
    // it owes, and an accepted result is checked against the oldest one owed.
    always @(posedge aclk) begin
        item_took = aresetn && s_valid && s_ready;
        if (item_took) begin
            accepted_n++;
            owed_q = {owed_q, alloc_predict('{gha_pkg::cmd_t'(s_command), s_handle_index,
                                              s_handle_generation})};
        end
        if (aresetn && m_valid && m_ready) begin
            if (owed_q.size() == 0) begin
                $error("result item arrived with none outstanding");
                fails++;
            end else begin
                want = owed_q.pop_front();
                check_field("status", want.status, m_status);
                check_field("new_index", want.new_index, m_new_index);
                check_field("new_generation", want.new_gen, m_new_generation);
                check_field("is_alive", want.alive, m_is_alive);
                check_field("live_count", want.live, m_live_count);
                check_field("freed_count", want.freed, m_freed_count);
            end
        end
    end

    // Watchdog: a hung handshake ends the run.
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("FAIL generational_handle_allocator");
            $finish;
        end
    end

    initial begin
        int unsigned n;
        int unsigned pick;
        bit          filled;
        filled = 1'b0;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part. A query and a commit on the empty allocator come first.
        queue_item(gha_pkg::CMD_ALIVE, TABLE_DEPTH, 0);
        queue_item(gha_pkg::CMD_COMMIT, 0, 0);
        // Three fresh slots, 0 to 2, all at generation 0.
        queue_item(gha_pkg::CMD_CREATE, 0, 0);
        queue_item(gha_pkg::CMD_CREATE, 2047, 16'hFFFF);
        queue_item(gha_pkg::CMD_CREATE, 0, 0);
        // A live handle, a wrong generation, a slot never used and an out-of-range index.
        queue_item(gha_pkg::CMD_ALIVE, 0, 0);
        queue_item(gha_pkg::CMD_ALIVE, 1, 5);
        queue_item(gha_pkg::CMD_ALIVE, 5, 0);
        queue_item(gha_pkg::CMD_ALIVE, 2047, 16'hFFFF);
        // The null handle and the largest index are refused rather than queued.
        queue_item(gha_pkg::CMD_DESTROY, TABLE_DEPTH, 0);
        queue_item(gha_pkg::CMD_DESTROY, 2047, 16'hFFFF);
        // The same handle queued twice and a stale one: the commit frees one slot only.
        queue_item(gha_pkg::CMD_DESTROY, 1, 0);
        queue_item(gha_pkg::CMD_DESTROY, 1, 0);
        queue_item(gha_pkg::CMD_DESTROY, 2, 7);
        queue_item(gha_pkg::CMD_COMMIT, 2047, 16'hFFFF);
        queue_item(gha_pkg::CMD_ALIVE, 1, 0);
        // Slot 1 comes back at generation 1, then a fresh slot 3.
        queue_item(gha_pkg::CMD_CREATE, 0, 0);
        queue_item(gha_pkg::CMD_CREATE, 0, 0);
        // Free two slots so that the free list is walked in last-freed-first order.
        queue_item(gha_pkg::CMD_DESTROY, 0, 0);
        queue_item(gha_pkg::CMD_DESTROY, 1, 1);
        queue_item(gha_pkg::CMD_COMMIT, 0, 0);
        queue_item(gha_pkg::CMD_CREATE, 0, 0);
        queue_item(gha_pkg::CMD_CREATE, 0, 0);

        // Hold the sender back until the block has answered everything so far.
        while (owed_q.size() != 0 || accepted_n != pushed_n) @(negedge aclk);

        // Random part, built stretch by stretch from the shadow state as it stands
        // once every item of the previous stretch has been taken.
        while (pushed_n < ITEMS_TOTAL) begin
            if (pushed_n + QUIET_TAIL >= ITEMS_TOTAL) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                pick      = $urandom_range(2);
                gap_pct   = (pick == 0) ? 0 : (pick == 1) ? 10 : 35;
                pick      = $urandom_range(2);
                stall_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : 35;
            end

            pick = $urandom_range(99);
            if (!filled && pushed_n >= FILL_AT) begin
                // Create until every slot is live, then a few more to see the table full.
                filled = 1'b1;
                n      = TABLE_DEPTH - live_now + 4;
                for (int k = 0; k < n; k++) begin
                    queue_item(gha_pkg::CMD_CREATE, $urandom_range(2047), $urandom);
                    if ($urandom_range(9) == 0)
                        queue_known(gha_pkg::CMD_ALIVE);
                end
            end else if (pick < 8) begin
                // Flood the destroy queue to its depth or past it, then commit it.
                n = $urandom_range(PENDING_DEPTH, PENDING_DEPTH + 8);
                for (int k = 0; k < n; k++)
                    queue_known(gha_pkg::CMD_DESTROY);
                queue_item(gha_pkg::CMD_COMMIT, $urandom_range(2047), $urandom);
            end else begin
                // The usual mix of well-formed traffic with some noise.
                n = $urandom_range(1, 30);
                for (int k = 0; k < n; k++) begin
                    pick = $urandom_range(99);
                    if (pick < 30)
                        queue_item(gha_pkg::CMD_CREATE, $urandom_range(2047), $urandom);
                    else if (pick < 60)
                        queue_known(gha_pkg::CMD_DESTROY);
                    else if (pick < 80)
                        queue_known(gha_pkg::CMD_ALIVE);
                    else if (pick < 88)
                        queue_item(gha_pkg::CMD_COMMIT, $urandom_range(2047), $urandom);
                    else
                        queue_item(gha_pkg::cmd_t'($urandom_range(3)),
                                   $urandom_range(2047), $urandom);
                end
            end

            while (accepted_n != pushed_n) @(negedge aclk);
            if ($urandom_range(9) == 0)
                while (owed_q.size() != 0) @(negedge aclk);
        end

        // Let the last results in, then give the block time to show anything spurious.
        while (owed_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (owed_q.size() != 0) begin
            $error("%0d result items never arrived", owed_q.size());
            fails++;
        end

        $display("Covered %0d items: %0d create, %0d destroy, %0d alive, %0d commit.",
                 accepted_n, n_cmd[gha_pkg::CMD_CREATE], n_cmd[gha_pkg::CMD_DESTROY],
                 n_cmd[gha_pkg::CMD_ALIVE], n_cmd[gha_pkg::CMD_COMMIT]);
        $display("Saw %0d table full, %0d queue full, %0d invalid, %0d live hits, %0d freed.",
                 n_full, n_qfull, n_invalid, n_hits, n_freed);
        if (fails == 0)
            $display("PASS generational_handle_allocator");
        else
            $display("FAIL generational_handle_allocator");
        $finish;
    end

endmodule
